// ===== rtl/core/csc_pkg.sv =====
// Shared types, widths, command codes and the arctangent table of the CORDIC core.
`default_nettype none

package csc_pkg;

	// Operand and result widths at the ports
	localparam int CMD_W = 2;
	localparam int XIN_W = 20;
	localparam int ZIN_W = 21;
	localparam int RES_W = 22;

	// Internal datapath widths: x/y gain about 1.65x over 16 steps, z moves by at most 409107
	localparam int XW = 24;
	localparam int ZW = 23;

	// Gain correction: (v * GAIN) >>> FRAC_BITS
	localparam int FRAC_BITS = 12;
	localparam int GAIN_W    = 13;
	localparam logic signed [GAIN_W-1:0] GAIN = 13'sd2487;
	localparam int PROD_W    = XW + GAIN_W;

	// Iteration count limits
	localparam int ITER_MAX = 16;
	localparam int ITER_DEF = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_COS  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SIN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ATAN = 2'd2;

	// One request as it travels down the rotation pipeline
	typedef struct packed {
		logic                 vld;
		logic [CMD_W-1:0]     cmd;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} csc_stage_t;

	// Arctangent of 2^-i in degrees, 12 fraction bits
	function automatic logic signed [ZW-1:0] atan_deg(input logic [3:0] idx);
		logic signed [ZW-1:0] a;
		unique case (idx)
			4'd0:    a = 23'sd184320;
			4'd1:    a = 23'sd108810;
			4'd2:    a = 23'sd57492;
			4'd3:    a = 23'sd29184;
			4'd4:    a = 23'sd14648;
			4'd5:    a = 23'sd7331;
			4'd6:    a = 23'sd3666;
			4'd7:    a = 23'sd1833;
			4'd8:    a = 23'sd916;
			4'd9:    a = 23'sd458;
			4'd10:   a = 23'sd229;
			4'd11:   a = 23'sd114;
			4'd12:   a = 23'sd57;
			4'd13:   a = 23'sd28;
			4'd14:   a = 23'sd14;
			default: a = 23'sd7;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cordic_sin_cos_arctan_core.sv =====
// Top level of the pipelined CORDIC core: cosine, sine and arctangent in degrees.
//
//  channel   signals                          handshake
//  --------  -------------------------------  ------------------------------
//  request   cmd, x_in, y_in, angle_in        start && !busy
//  result    result_value                     done, one cycle, no back-pressure
//
// One request enters every cycle; busy stays low.
// The pipeline holds one register per micro-rotation (ITERATIONS, capped at ITER_MAX),
// then one for the gain multiply and one for the shift and clamp.
// Reset clears only the valid bits along the pipeline; data registers are not reset.
// Nothing stalls: the result strobe cannot be held off.
`default_nettype none

module cordic_sin_cos_arctan_core
	import csc_pkg::*;
#(
	parameter int ITERATIONS = ITER_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [CMD_W-1:0]         cmd,
	input  wire logic signed [XIN_W-1:0]  x_in,
	input  wire logic signed [XIN_W-1:0]  y_in,
	input  wire logic signed [ZIN_W-1:0]  angle_in,
	output logic                          done,
	output logic signed [RES_W-1:0]       result_value
);

	localparam int N = (ITERATIONS > ITER_MAX) ? ITER_MAX : ITERATIONS;

	csc_stage_t pipe [N+1];

	assign busy = 1'b0;

	// Load a request into the head of the pipeline
	always_comb begin
		pipe[0].vld = start && !busy;
		pipe[0].cmd = cmd;
		pipe[0].x   = XW'(x_in);
		pipe[0].y   = XW'(y_in);
		pipe[0].z   = ZW'(angle_in);
	end

	// One registered micro-rotation per iteration
	for (genvar i = 0; i < N; i++) begin : g_rot
		csc_stage #(
			.SHIFT (i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (pipe[i]),
			.q      (pipe[i+1])
		);
	end

	csc_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.d            (pipe[N]),
		.done         (done),
		.result_value (result_value)
	);

endmodule

`default_nettype wire

// ===== rtl/core/csc_stage.sv =====
// One registered CORDIC micro-rotation with a fixed shift.
`default_nettype none

module csc_stage
	import csc_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire csc_stage_t d,
	output csc_stage_t      q
);

	logic                 pos;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] a;
	csc_stage_t           nxt;
	logic                 vld_s1;
	csc_stage_t           pipe_s1;

	// Pick the rotation direction; a zero residual or zero y rotates negatively
	always_comb begin
		pos = (d.cmd == CMD_ATAN) ? (d.y < 0) : (d.z > 0);
		xs  = d.x >>> SHIFT;
		ys  = d.y >>> SHIFT;
		a   = atan_deg(4'(SHIFT));
		nxt = d;
		if (pos) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - a;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + a;
		end
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= d.vld;
		end
	end

	// Hold the payload of the request
	always_ff @(posedge clk) begin
		pipe_s1 <= nxt;
	end

	always_comb begin
		q     = pipe_s1;
		q.vld = vld_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/core/csc_post.sv =====
// Gain correction, result select and saturation after the last micro-rotation.
`default_nettype none

module csc_post
	import csc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire csc_stage_t             d,
	output logic                        done,
	output logic signed [RES_W-1:0]     result_value
);

	localparam int SH_W = PROD_W - FRAC_BITS;
	localparam logic signed [SH_W-1:0] RES_MIN = -(SH_W'(1) <<< (RES_W - 1));
	localparam logic signed [SH_W-1:0] RES_MAX = (SH_W'(1) <<< (RES_W - 1)) - SH_W'(1);

	logic signed [XW-1:0]     sel;
	logic signed [PROD_W-1:0] prod;
	logic                     vld_s1;
	logic                     rot_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ZW-1:0]     z_s1;
	logic signed [SH_W-1:0]   raw;
	logic signed [RES_W-1:0]  sat;
	logic                     vld_s2;
	logic signed [RES_W-1:0]  res_s2;

	// Multiply x (cos) or y (sin) by the gain
	always_comb begin
		sel  = (d.cmd == CMD_COS) ? d.x : d.y;
		prod = PROD_W'(sel) * PROD_W'(GAIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= d.vld;
			vld_s2 <= vld_s1;
		end
	end

	// Hold the product and the residual angle
	always_ff @(posedge clk) begin
		rot_s1  <= (d.cmd == CMD_COS) || (d.cmd == CMD_SIN);
		prod_s1 <= prod;
		z_s1    <= d.z;
	end

	// Drop the fraction bits or take the angle, then clamp to the result range
	always_comb begin
		raw = rot_s1 ? SH_W'(prod_s1 >>> FRAC_BITS) : SH_W'(z_s1);
		priority if (raw < RES_MIN) begin
			sat = RES_MIN[RES_W-1:0];
		end else if (raw > RES_MAX) begin
			sat = RES_MAX[RES_W-1:0];
		end else begin
			sat = raw[RES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= sat;
	end

	assign done         = vld_s2;
	assign result_value = res_s2;

endmodule

`default_nettype wire

// ===== rtl/core/csc_chk.sv =====
// Port-level checker for the CORDIC core and its bind to the top level.
`default_nettype none

module csc_chk
	import csc_pkg::*;
#(
	parameter int LATENCY = ITER_DEF + 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire logic                     done,
	input  wire logic signed [RES_W-1:0]  result_value
);

	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

	// Every accepted request yields a result after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request not answered after pipeline latency");

	// No result appears without a request the fixed latency earlier
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without matching request");

	// The pipeline never pushes back
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a non-stalling pipeline");

	// No result ever sits at either clamp limit
	a_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_value != RES_MIN) && (result_value != RES_MAX))
		else $error("result hit the saturation limit");

endmodule

bind cordic_sin_cos_arctan_core csc_chk #(
	.LATENCY (((ITERATIONS > 16) ? 16 : ITERATIONS) + 2)
) u_csc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_value (result_value)
);

`default_nettype wire
